/* src/gte_pkg.sv */
`timescale 1ns / 1ps
package gte_pkg;

  localparam int unsigned VERT_W      = 5;
  localparam int unsigned MAX_RESULTS = 32;
  localparam int unsigned RCW         = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] CMD_ADD_EDGE = 2'd0;
  localparam logic [1:0] CMD_BFS      = 2'd1;
  localparam logic [1:0] CMD_DFS      = 2'd2;

  localparam logic [1:0] KIND_STORED   = 2'd0;
  localparam logic [1:0] KIND_REJECTED = 2'd1;
  localparam logic [1:0] KIND_VISIT    = 2'd2;

  typedef struct packed {
    logic [1:0]        command;
    logic [VERT_W-1:0] first_vertex;
    logic [VERT_W-1:0] second_vertex;
  } gte_cmd_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [VERT_W-1:0] vertex;
    logic              last;
  } gte_res_t;

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_EDGE_A    = 13'b0000000000010,
    S_EDGE_B    = 13'b0000000000100,
    S_EDGE_W2   = 13'b0000000001000,
    S_B_POP     = 13'b0000000010000,
    S_B_LOAD    = 13'b0000000100000,
    S_B_SCAN    = 13'b0000001000000,
    S_B_CHK     = 13'b0000010000000,
    S_D_DEG     = 13'b0000100000000,
    S_D_STEP    = 13'b0001000000000,
    S_D_CHK     = 13'b0010000000000,
    S_D_RESTORE = 13'b0100000000000,
    S_FINISH    = 13'b1000000000000
  } gte_state_e;

endpackage

/* src/gte_ram.sv */
`timescale 1ns / 1ps
module gte_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 5
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

/* src/graph_traversal_engine_core.sv */
`timescale 1ns / 1ps
// Graph traversal engine: undirected graph of up to NUM_VERTICES vertices with
// MAX_DEGREE neighbor slots each. An item is taken when start is high and busy
// is low. Its results are strobed on result_valid_o with last set on the final
// one, and busy drops in the cycle that carries that final result. Command 3
// and a traversal from a vertex beyond the graph are taken with no results and
// without raising busy. The receiver cannot stall: each result is present for
// exactly one cycle. An add-edge item steps through S_EDGE_A, S_EDGE_B and
// S_EDGE_W2; a rejected edge is answered from S_EDGE_B. Breadth-first passes
// S_B_POP, S_B_LOAD and S_B_SCAN per visited vertex and S_B_CHK per stored
// neighbor entry, then S_FINISH. Depth-first passes S_D_STEP and S_D_CHK per
// neighbor entry scanned, S_D_DEG per visited vertex, S_D_RESTORE per
// backtrack and S_FINISH at the end. The neighbor memory has a single read port.
module graph_traversal_engine_core
  import gte_pkg::*;
#(
  parameter int unsigned NUM_VERTICES = 32,
  parameter int unsigned MAX_DEGREE   = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  gte_cmd_t item_i,
  output logic     result_valid_o,
  output gte_res_t result_o
);

  localparam int unsigned VIW = $clog2(NUM_VERTICES);
  localparam int unsigned DW  = $clog2(MAX_DEGREE + 1);
  localparam int unsigned IW  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int unsigned AW  = VIW + IW;
  localparam int unsigned CW  = $clog2(NUM_VERTICES + 1);
  localparam int unsigned FW  = VERT_W + DW;

  gte_state_e state_q, state_d;

  logic [VERT_W-1:0]   a_q, a_d, b_q, b_d;
  logic                range_ok_q, range_ok_d;
  logic [DW-1:0]       dega_q, dega_d, degb_q, degb_d;
  logic [VERT_W-1:0]   cur_v_q, cur_v_d;
  logic [DW-1:0]       cur_nx_q, cur_nx_d;
  logic [DW-1:0]       cur_deg_q, cur_deg_d;
  logic [CW-1:0]       head_q, head_d, tail_q, tail_d, depth_q, depth_d;
  logic [RCW-1:0]      cnt_q, cnt_d;
  logic [NUM_VERTICES-1:0] visited_q, visited_d;
  logic [DW-1:0]       deg_q [NUM_VERTICES];
  logic                pend_valid_q, pend_valid_d;
  logic [VERT_W-1:0]   pend_vertex_q, pend_vertex_d;
  logic                res_valid_q, res_valid_d;
  gte_res_t            res_q, res_d;

  logic                deg_we;
  logic [VIW-1:0]      deg_waddr, deg_raddr;
  logic [DW-1:0]       deg_wdata, deg_rd;

  logic                nb_we;
  logic [AW-1:0]       nb_waddr, nb_raddr;
  logic [VERT_W-1:0]   nb_wdata, nb_rdata;

  logic                fr_we;
  logic [VIW-1:0]      fr_waddr, fr_raddr;
  logic [FW-1:0]       fr_wdata, fr_rdata;
  logic [VERT_W-1:0]   fr_rd_v;
  logic [DW-1:0]       fr_rd_nx;

  logic                prod;
  logic [VERT_W-1:0]   prod_v;
  logic                self_loop, edge_ok, a_in, b_in;
  logic [DW:0]         dega_p2;
  logic [CW-1:0]       depth_m1, depth_m2;
  logic [DW-1:0]       dega_p1;

  gte_ram #(
    .DEPTH(2 ** AW),
    .WIDTH(VERT_W)
  ) u_nbr_mem (
    .clk_i    (clk_i),
    .wr_en_i  (nb_we),
    .wr_addr_i(nb_waddr),
    .wr_data_i(nb_wdata),
    .rd_addr_i(nb_raddr),
    .rd_data_o(nb_rdata)
  );

  gte_ram #(
    .DEPTH(NUM_VERTICES),
    .WIDTH(FW)
  ) u_frontier_mem (
    .clk_i    (clk_i),
    .wr_en_i  (fr_we),
    .wr_addr_i(fr_waddr),
    .wr_data_i(fr_wdata),
    .rd_addr_i(fr_raddr),
    .rd_data_o(fr_rdata)
  );

  assign fr_rd_v  = fr_rdata[FW-1 -: VERT_W];
  assign fr_rd_nx = fr_rdata[DW-1:0];
  assign deg_rd   = deg_q[deg_raddr];

  assign a_in      = 7'(item_i.first_vertex) < 7'(NUM_VERTICES);
  assign b_in      = 7'(item_i.second_vertex) < 7'(NUM_VERTICES);
  assign self_loop = (a_q == b_q);
  assign dega_p2   = {1'b0, dega_q} + (DW + 1)'(2);
  assign dega_p1   = dega_q + DW'(1);
  assign edge_ok   = range_ok_q &&
                     (self_loop ? (dega_p2 <= (DW + 1)'(MAX_DEGREE))
                                : (dega_q < DW'(MAX_DEGREE) && deg_rd < DW'(MAX_DEGREE)));
  assign depth_m1  = depth_q - CW'(1);
  assign depth_m2  = depth_q - CW'(2);

  always_comb begin
    state_d       = state_q;
    a_d           = a_q;
    b_d           = b_q;
    range_ok_d    = range_ok_q;
    dega_d        = dega_q;
    degb_d        = degb_q;
    cur_v_d       = cur_v_q;
    cur_nx_d      = cur_nx_q;
    cur_deg_d     = cur_deg_q;
    head_d        = head_q;
    tail_d        = tail_q;
    depth_d       = depth_q;
    cnt_d         = cnt_q;
    visited_d     = visited_q;
    pend_valid_d  = pend_valid_q;
    pend_vertex_d = pend_vertex_q;
    res_valid_d   = 1'b0;
    res_d         = res_q;
    deg_we        = 1'b0;
    deg_waddr     = VIW'(a_q);
    deg_wdata     = dega_q;
    deg_raddr     = VIW'(cur_v_q);
    nb_we         = 1'b0;
    nb_waddr      = {VIW'(a_q), dega_q[IW-1:0]};
    nb_wdata      = b_q;
    nb_raddr      = {VIW'(cur_v_q), cur_nx_q[IW-1:0]};
    fr_we         = 1'b0;
    fr_waddr      = tail_q[VIW-1:0];
    fr_wdata      = {cur_v_q, cur_nx_q};
    fr_raddr      = head_q[VIW-1:0];
    prod          = 1'b0;
    prod_v        = cur_v_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          a_d        = item_i.first_vertex;
          b_d        = item_i.second_vertex;
          range_ok_d = a_in && b_in;
          cur_v_d    = item_i.first_vertex;
          cur_nx_d   = '0;
          cnt_d      = '0;
          if (item_i.command == CMD_ADD_EDGE) begin
            state_d = S_EDGE_A;
          end else if (item_i.command == CMD_BFS && a_in) begin
            visited_d = '0;
            visited_d[VIW'(item_i.first_vertex)] = 1'b1;
            fr_we    = 1'b1;
            fr_waddr = '0;
            fr_wdata = {item_i.first_vertex, DW'(0)};
            head_d   = '0;
            tail_d   = CW'(1);
            state_d  = S_B_POP;
          end else if (item_i.command == CMD_DFS && a_in) begin
            visited_d = '0;
            visited_d[VIW'(item_i.first_vertex)] = 1'b1;
            prod     = 1'b1;
            prod_v   = item_i.first_vertex;
            cnt_d    = RCW'(1);
            depth_d  = CW'(1);
            state_d  = S_D_DEG;
          end
        end
      end
      S_EDGE_A: begin
        deg_raddr = VIW'(a_q);
        dega_d    = deg_rd;
        state_d   = S_EDGE_B;
      end
      S_EDGE_B: begin
        deg_raddr = VIW'(b_q);
        degb_d    = deg_rd;
        if (edge_ok) begin
          nb_we     = 1'b1;
          deg_we    = 1'b1;
          deg_waddr = VIW'(a_q);
          deg_wdata = self_loop ? dega_p2[DW-1:0] : dega_p1;
          state_d   = S_EDGE_W2;
        end else begin
          res_valid_d = 1'b1;
          res_d       = '{kind: KIND_REJECTED, vertex: '0, last: 1'b1};
          state_d     = S_IDLE;
        end
      end
      S_EDGE_W2: begin
        nb_we     = 1'b1;
        nb_waddr  = {VIW'(b_q), self_loop ? dega_p1[IW-1:0] : degb_q[IW-1:0]};
        nb_wdata  = a_q;
        deg_we    = !self_loop;
        deg_waddr = VIW'(b_q);
        deg_wdata = degb_q + DW'(1);
        res_valid_d = 1'b1;
        res_d       = '{kind: KIND_STORED, vertex: '0, last: 1'b1};
        state_d     = S_IDLE;
      end
      S_B_POP: begin
        if (head_q < tail_q && cnt_q < RCW'(MAX_RESULTS)) begin
          head_d  = head_q + CW'(1);
          state_d = S_B_LOAD;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_B_LOAD: begin
        cur_v_d   = fr_rd_v;
        deg_raddr = VIW'(fr_rd_v);
        cur_deg_d = deg_rd;
        cur_nx_d  = '0;
        prod      = 1'b1;
        prod_v    = fr_rd_v;
        cnt_d     = cnt_q + RCW'(1);
        state_d   = S_B_SCAN;
      end
      S_B_SCAN: begin
        if (cur_nx_q < cur_deg_q) begin
          cur_nx_d = cur_nx_q + DW'(1);
          state_d  = S_B_CHK;
        end else begin
          state_d = S_B_POP;
        end
      end
      S_B_CHK: begin
        if (!visited_q[VIW'(nb_rdata)]) begin
          visited_d[VIW'(nb_rdata)] = 1'b1;
          fr_we    = 1'b1;
          fr_wdata = {nb_rdata, DW'(0)};
          tail_d   = tail_q + CW'(1);
        end
        if (cur_nx_q < cur_deg_q) begin
          cur_nx_d = cur_nx_q + DW'(1);
        end else begin
          state_d = S_B_POP;
        end
      end
      S_D_DEG: begin
        cur_deg_d = deg_rd;
        state_d   = S_D_STEP;
      end
      S_D_STEP: begin
        fr_raddr = depth_m2[VIW-1:0];
        if (cnt_q >= RCW'(MAX_RESULTS)) begin
          state_d = S_FINISH;
        end else if (cur_nx_q < cur_deg_q) begin
          cur_nx_d = cur_nx_q + DW'(1);
          state_d  = S_D_CHK;
        end else begin
          depth_d = depth_m1;
          state_d = (depth_q == CW'(1)) ? S_FINISH : S_D_RESTORE;
        end
      end
      S_D_CHK: begin
        if (!visited_q[VIW'(nb_rdata)]) begin
          visited_d[VIW'(nb_rdata)] = 1'b1;
          prod     = 1'b1;
          prod_v   = nb_rdata;
          cnt_d    = cnt_q + RCW'(1);
          fr_we    = 1'b1;
          fr_waddr = depth_m1[VIW-1:0];
          fr_wdata = {cur_v_q, cur_nx_q};
          cur_v_d  = nb_rdata;
          cur_nx_d = '0;
          depth_d  = depth_q + CW'(1);
          state_d  = S_D_DEG;
        end else begin
          state_d = S_D_STEP;
        end
      end
      S_D_RESTORE: begin
        cur_v_d  = fr_rd_v;
        cur_nx_d = fr_rd_nx;
        state_d  = S_D_DEG;
      end
      S_FINISH: begin
        res_valid_d  = pend_valid_q;
        res_d        = '{kind: KIND_VISIT, vertex: pend_vertex_q, last: 1'b1};
        pend_valid_d = 1'b0;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // hold back one visit so the final one can carry last
    if (prod) begin
      if (pend_valid_q) begin
        res_valid_d = 1'b1;
        res_d       = '{kind: KIND_VISIT, vertex: pend_vertex_q, last: 1'b0};
      end
      pend_valid_d  = 1'b1;
      pend_vertex_d = prod_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      tail_q       <= '0;
      depth_q      <= '0;
      cnt_q        <= '0;
      visited_q    <= '0;
      pend_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
      for (int i = 0; i < NUM_VERTICES; i++) begin
        deg_q[i] <= '0;
      end
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      depth_q      <= depth_d;
      cnt_q        <= cnt_d;
      visited_q    <= visited_d;
      pend_valid_q <= pend_valid_d;
      res_valid_q  <= res_valid_d;
      if (deg_we) begin
        deg_q[deg_waddr] <= deg_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q           <= a_d;
    b_q           <= b_d;
    range_ok_q    <= range_ok_d;
    dega_q        <= dega_d;
    degb_q        <= degb_d;
    cur_v_q       <= cur_v_d;
    cur_nx_q      <= cur_nx_d;
    cur_deg_q     <= cur_deg_d;
    pend_vertex_q <= pend_vertex_d;
    res_q         <= res_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

`ifndef SYNTHESIS
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_valid_q)
    else $error("visit held back while idle");

  a_edge_answer_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_o.kind == KIND_STORED || result_o.kind == KIND_REJECTED))
      |-> result_o.last)
    else $error("edge answer without last");

  a_edge_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.command == CMD_ADD_EDGE) |=> busy)
    else $error("add-edge item did not start");

  a_result_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= RCW'(MAX_RESULTS))
    else $error("result count overrun");

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (depth_q <= CW'(NUM_VERTICES)) && (tail_q <= CW'(NUM_VERTICES)))
    else $error("frontier overrun");
`endif

endmodule

/* verif/graph_traversal_engine_core_tb.sv */
`timescale 1ns / 1ps
module graph_traversal_engine_core_tb;
  import gte_pkg::*;

  localparam int unsigned NV         = 32;
  localparam int unsigned MAX_DEG    = 8;
  localparam int          STALL_LIMIT = 10000;
  localparam int          DRAIN_CYCLES = 50;
  localparam int          MAX_PRINTS  = 50;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;

  typedef struct {
    gte_cmd_t cmd;
    int       idle_pct;
  } pending_t;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  gte_cmd_t item_i;
  logic     result_valid_o;
  gte_res_t result_o;

  pending_t pending_items[$];
  pending_t next_req;
  gte_res_t expected_answers[$];
  gte_res_t want;
  int       mismatch_count;
  int       stall_cycles;

  // graph as the block should hold it
  logic [VERT_W-1:0] nbr_list[NV][MAX_DEG];
  int                nbr_count[NV];
  bit                seen[NV];

  graph_traversal_engine_core #(
    .NUM_VERTICES(NV),
    .MAX_DEGREE  (MAX_DEG)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  task automatic predict_answers(input gte_cmd_t c);
    gte_res_t          out_r[MAX_RESULTS];
    gte_res_t          r;
    logic [VERT_W-1:0] fifo_v[NV];
    logic [VERT_W-1:0] stk_v[NV];
    int                stk_n[NV];
    logic [VERT_W-1:0] a, b, v, nb;
    int                head, tail, depth, n;
    logic              ok;
    a = c.first_vertex;
    b = c.second_vertex;
    n = 0;
    case (c.command)
      CMD_ADD_EDGE: begin
        ok = 1'b0;
        if (a == b) begin
          if (nbr_count[a] + 2 <= MAX_DEG) begin
            nbr_list[a][nbr_count[a]]     = a;
            nbr_list[a][nbr_count[a] + 1] = a;
            nbr_count[a] += 2;
            ok = 1'b1;
          end
        end else if (nbr_count[a] < MAX_DEG && nbr_count[b] < MAX_DEG) begin
          nbr_list[a][nbr_count[a]] = b;
          nbr_list[b][nbr_count[b]] = a;
          nbr_count[a]++;
          nbr_count[b]++;
          ok = 1'b1;
        end
        out_r[0].kind   = ok ? KIND_STORED : KIND_REJECTED;
        out_r[0].vertex = '0;
        n = 1;
      end
      CMD_BFS: begin
        for (int i = 0; i < NV; i++) seen[i] = 1'b0;
        head = 0;
        tail = 1;
        fifo_v[0] = a;
        seen[a] = 1'b1;
        while (head < tail && n < MAX_RESULTS) begin
          v = fifo_v[head];
          head++;
          out_r[n].kind   = KIND_VISIT;
          out_r[n].vertex = v;
          n++;
          for (int i = 0; i < nbr_count[v]; i++) begin
            nb = nbr_list[v][i];
            if (!seen[nb] && tail < NV) begin
              seen[nb] = 1'b1;
              fifo_v[tail] = nb;
              tail++;
            end
          end
        end
      end
      CMD_DFS: begin
        for (int i = 0; i < NV; i++) seen[i] = 1'b0;
        seen[a] = 1'b1;
        out_r[0].kind   = KIND_VISIT;
        out_r[0].vertex = a;
        n = 1;
        stk_v[0] = a;
        stk_n[0] = 0;
        depth = 1;
        while (depth > 0 && n < MAX_RESULTS) begin
          v = stk_v[depth-1];
          if (stk_n[depth-1] < nbr_count[v]) begin
            nb = nbr_list[v][stk_n[depth-1]];
            stk_n[depth-1]++;
            if (!seen[nb] && depth < NV) begin
              seen[nb] = 1'b1;
              out_r[n].kind   = KIND_VISIT;
              out_r[n].vertex = nb;
              n++;
              stk_v[depth] = nb;
              stk_n[depth] = 0;
              depth++;
            end
          end else begin
            depth--;
          end
        end
      end
      default: ;
    endcase
    for (int i = 0; i < n; i++) begin
      r      = out_r[i];
      r.last = (i == n - 1);
      expected_answers.insert(expected_answers.size(), r);
    end
  endtask

  // driver: start held until the block takes the item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start  <= 1'b0;
      item_i <= '0;
    end else begin
      if (start && !busy) begin
        predict_answers(item_i);
      end
      if (!start || !busy) begin
        if (pending_items.size() > 0 &&
            $urandom_range(99) >= pending_items[0].idle_pct) begin
          next_req = pending_items.pop_front();
          start  <= 1'b1;
          item_i <= next_req.cmd;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_answers.size() == 0) begin
        flag_mismatch($sformatf("unexpected result kind=%0d vertex=%0d last=%0b",
                                result_o.kind, result_o.vertex, result_o.last));
      end else begin
        want = expected_answers.pop_front();
        if (result_o.kind !== want.kind)
          flag_mismatch($sformatf("kind %0d, want %0d", result_o.kind, want.kind));
        if (result_o.vertex !== want.vertex)
          flag_mismatch($sformatf("vertex %0d, want %0d", result_o.vertex, want.vertex));
        if (result_o.last !== want.last)
          flag_mismatch($sformatf("last %0b, want %0b", result_o.last, want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("graph_traversal_engine_core: mismatch");
        $finish;
      end
    end
  end

  task automatic queue_item(input logic [1:0] cmd, input int a, input int b, input int pct);
    pending_t p;
    p.cmd.command       = cmd;
    p.cmd.first_vertex  = a[VERT_W-1:0];
    p.cmd.second_vertex = b[VERT_W-1:0];
    p.idle_pct          = pct;
    pending_items.insert(pending_items.size(), p);
  endtask

  initial begin
    int          roll, pct, a, b;
    logic [1:0]  cmd;
    rst_ni         = 1'b0;
    mismatch_count = 0;
    stall_cycles   = 0;
    for (int i = 0; i < NV; i++) begin
      nbr_count[i] = 0;
      seen[i]      = 1'b0;
    end

    // empty graph, then list limits and self loops
    queue_item(CMD_DFS, 0, 31, 31);
    queue_item(CMD_BFS, 31, 0, 31);
    queue_item(CMD_ADD_EDGE, 0, 31, 31);
    queue_item(CMD_ADD_EDGE, 0, 1, 31);
    queue_item(CMD_ADD_EDGE, 5, 5, 31);
    queue_item(CMD_ADD_EDGE, 5, 5, 31);
    queue_item(CMD_ADD_EDGE, 5, 5, 31);
    queue_item(CMD_ADD_EDGE, 5, 6, 31);
    queue_item(CMD_ADD_EDGE, 5, 5, 31);
    queue_item(CMD_ADD_EDGE, 5, 7, 31);
    queue_item(CMD_ADD_EDGE, 5, 8, 31);
    queue_item(CMD_ADD_EDGE, 9, 5, 31);
    queue_item(CMD_ADD_EDGE, 31, 31, 31);
    queue_item(CMD_ADD_EDGE, 31, 30, 31);
    queue_item(CMD_BFS, 0, 0, 31);
    queue_item(CMD_DFS, 0, 0, 31);
    queue_item(CMD_BFS, 5, 0, 31);
    queue_item(CMD_DFS, 5, 0, 31);
    queue_item(CMD_UNUSED, 31, 31, 31);
    queue_item(CMD_BFS, 31, 31, 31);
    queue_item(CMD_DFS, 31, 31, 31);

    for (int phase = 0; phase < 3; phase++) begin
      pct = (phase == 0) ? 31 : (phase == 1) ? 66 : 0;
      for (int k = 0; k < 118; k++) begin
        roll = $urandom_range(99);
        a    = $urandom_range(31);
        b    = $urandom_range(31);
        if (roll < 45) begin
          cmd = CMD_ADD_EDGE;
          if ($urandom_range(9) == 0) b = a;
        end else if (roll < 70) begin
          cmd = CMD_BFS;
        end else if (roll < 95) begin
          cmd = CMD_DFS;
        end else begin
          cmd = CMD_UNUSED;
        end
        queue_item(cmd, a, b, pct);
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (pending_items.size() > 0 || start || busy || expected_answers.size() > 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_answers.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", expected_answers.size()));
    if (mismatch_count == 0) begin
      $display("graph_traversal_engine_core: match");
    end else begin
      $display("graph_traversal_engine_core: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/gte_pkg.sv
src/gte_ram.sv
src/graph_traversal_engine_core.sv
verif/graph_traversal_engine_core_tb.sv
